### sv/shrc_pkg.sv
// ============================================================================
// shrc_pkg
// Shared constants, tables and helper functions of the sector radial-cut
// histogrammer.
// ============================================================================
`default_nettype none

package shrc_pkg;

  localparam int unsigned MIN_MOMENTUM = 256;
  localparam int unsigned HALF_STEPS   = 28;
  localparam int unsigned LAST_STEP    = 27;
  localparam int unsigned BIN_RECIP    = 52429;
  localparam int unsigned BIN_SHIFT    = 22;
  localparam int unsigned NUM_SEC      = 3;

  localparam logic [1:0] CFG_RING   = 2'd0;
  localparam logic [1:0] CFG_QUARTZ = 2'd1;
  localparam logic [1:0] CFG_MOLLER = 2'd2;
  localparam logic [1:0] CFG_DETSEL = 2'd3;

  localparam logic [1:0] CLS_CLOSED = 2'd0;
  localparam logic [1:0] CLS_TRANS  = 2'd1;
  localparam logic [1:0] CLS_OPEN   = 2'd2;

  localparam logic [1:0] HSEL_ALL = 2'd0;

  localparam logic [2:0] RING_RESET   = 3'd1;
  localparam logic [7:0] DETSEL_RESET = 8'd28;

  function automatic logic signed [17:0] cos_q(input logic [3:0] j);
    logic signed [17:0] v;
    unique case (j)
      4'd0:    v = 18'sd65536;
      4'd1:    v = 18'sd65124;
      4'd2:    v = 18'sd63893;
      4'd3:    v = 18'sd61858;
      4'd4:    v = 18'sd59046;
      4'd5:    v = 18'sd55491;
      4'd6:    v = 18'sd51238;
      4'd7:    v = 18'sd46341;
      4'd8:    v = 18'sd40861;
      4'd9:    v = 18'sd34867;
      4'd10:   v = 18'sd28435;
      4'd11:   v = 18'sd21645;
      4'd12:   v = 18'sd14583;
      4'd13:   v = 18'sd7338;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] step_cos(input logic [4:0] k);
    logic [4:0] m;
    m = 5'd28 - k;
    if (k <= 5'd14) begin
      return cos_q(k[3:0]);
    end
    return -cos_q(m[3:0]);
  endfunction

  function automatic logic signed [17:0] step_sin(input logic [4:0] k);
    logic [4:0] m;
    m = (k <= 5'd14) ? (5'd14 - k) : (k - 5'd14);
    return cos_q(m[3:0]);
  endfunction

  function automatic logic [16:0] pick3(input logic [1:0] cls, input logic [16:0] a,
                                        input logic [16:0] b, input logic [16:0] c);
    logic [16:0] v;
    priority case (cls)
      CLS_CLOSED: v = a;
      CLS_TRANS:  v = b;
      default:    v = c;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] win_lo(input logic q, input logic [2:0] ring,
                                         input logic [1:0] cls);
    logic [16:0] v;
    unique case ({q, ring})
      4'b0001: v = 17'd10880;
      4'b0010: v = 17'd11680;
      4'b0011: v = pick3(cls, 17'd13360, 17'd13240, 17'd12880);
      4'b0100: v = pick3(cls, 17'd14640, 17'd14400, 17'd13680);
      4'b0101: v = pick3(cls, 17'd16880, 17'd16960, 17'd17120);
      4'b0110: v = 17'd18720;
      4'b1001: v = 17'd10240;
      4'b1010: v = 17'd10880;
      4'b1011: v = 17'd11680;
      4'b1100: v = pick3(cls, 17'd13360, 17'd13240, 17'd12880);
      4'b1101: v = 17'd9600;
      4'b1110: v = pick3(cls, 17'd16880, 17'd16960, 17'd17120);
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] win_hi(input logic q, input logic [2:0] ring,
                                         input logic [1:0] cls);
    logic [16:0] v;
    unique case ({q, ring})
      4'b1001: v = 17'd10880;
      4'b1010: v = 17'd11680;
      4'b1011: v = pick3(cls, 17'd13360, 17'd13240, 17'd12880);
      4'b1100: v = pick3(cls, 17'd14640, 17'd14400, 17'd13680);
      4'b1101: v = 17'd20800;
      4'b1110: v = 17'd18720;
      default: v = 17'd30400;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic        mode;
    logic        det_ok;
    logic        mom_ok;
    logic        trk_ok;
    logic [1:0]  hsel;
    logic        half;
    logic        origin;
    logic [16:0] radius;
  } item_t;

endpackage

`default_nettype wire

### sv/shrc_ram.sv
// ============================================================================
// shrc_ram
// Generic single-port-write, single-port-read memory with registered read.
// ============================================================================
`default_nettype none

module shrc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 401
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/shrc_angle.sv
// ============================================================================
// shrc_angle
// Five-stage binary search for the pi/28 step count of an angle in the upper
// half plane, one cross-product comparison per stage.
// ============================================================================
`default_nettype none

module shrc_angle (
  input  wire                clk,
  input  wire signed [18:0]  x,
  input  wire signed [18:0]  y,
  output logic [4:0]         n
);
  import shrc_pkg::*;

  localparam int unsigned STAGES = 5;

  logic signed [18:0] xs [STAGES];
  logic signed [18:0] ys [STAGES];
  logic [4:0]         ns [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic signed [18:0] xi;
    logic signed [18:0] yi;
    logic [4:0]         ni;
    logic [4:0]         t;
    logic signed [37:0] diff;
    logic               take;

    if (g == 0) begin : g_first
      assign xi = x;
      assign yi = y;
      assign ni = 5'd0;
    end else begin : g_next
      assign xi = xs[g-1];
      assign yi = ys[g-1];
      assign ni = ns[g-1];
    end

    assign t    = ni + 5'(16 >> g);
    assign diff = 38'(step_cos(t)) * 38'(yi) - 38'(step_sin(t)) * 38'(xi);
    assign take = (t <= 5'(LAST_STEP)) && !diff[37];

    always_ff @(posedge clk) begin
      xs[g] <= xi;
      ys[g] <= yi;
      ns[g] <= take ? t : ni;
    end
  end

  assign n = ns[STAGES-1];

endmodule

`default_nettype wire

### sv/shrc_fifo.sv
// ============================================================================
// shrc_fifo
// Result queue between the update pipeline and the output channel.
// ============================================================================
`default_nettype none

module shrc_fifo #(
  parameter int unsigned WIDTH = 76,
  parameter int unsigned DEPTH = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  wire [WIDTH-1:0]   din,
  input  wire               pop,
  output logic [WIDTH-1:0]  dout,
  output logic              empty
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) begin
      slots[wptr] <= din;
    end
  end

  assign dout  = slots[rptr];
  assign empty = (count == '0);

endmodule

`default_nettype wire

### sv/sector_radial_cut_histogrammer_core.sv
// ============================================================================
// sector_radial_cut_histogrammer_core
// Classifies hits by sevenfold azimuthal sector and radial window and adds
// their weights into saturating radial histograms held in block memory.
// ============================================================================
//  Channel  | Handshake           | Payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid/in_ready   | mode ... bin_index, one request per hit/read
//  out      | out_valid/out_ready | accepted, sector_class, hit_bin, bin_value
//  cfg      | cfg_we              | cfg_index, cfg_data
//
// One request is accepted per cycle while in_ready is high; each result passes
// through the five-stage angle search and the memory read-modify-write.
// After reset a clearing pass zeroes the histogram memories, during which
// in_ready is low. Up to sixteen requests may be outstanding; a stalled output
// fills the result queue and then holds in_ready low.
// ============================================================================
`default_nettype none

module sector_radial_cut_histogrammer_core #(
  parameter int unsigned HIST_BINS = 400,
  parameter int unsigned ACC_WIDTH = 64
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             mode,
  input  wire [7:0]                       detector_id,
  input  wire [15:0]                      track_id,
  input  wire [23:0]                      momentum,
  input  wire signed [17:0]               pos_x,
  input  wire signed [17:0]               pos_y,
  input  wire [16:0]                      radius,
  input  wire [31:0]                      rate,
  input  wire signed [31:0]               asymmetry,
  input  wire [1:0]                       hist_select,
  input  wire [$clog2(HIST_BINS+1)-1:0]   bin_index,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic                            accepted,
  output logic [1:0]                      sector_class,
  output logic [$clog2(HIST_BINS+1)-1:0]  hit_bin,
  output logic signed [63:0]              bin_value,
  input  wire                             cfg_we,
  input  wire [1:0]                       cfg_index,
  input  wire [7:0]                       cfg_data
);
  import shrc_pkg::*;

  localparam int unsigned NSLOT  = HIST_BINS + 1;
  localparam int unsigned BIN_W  = $clog2(HIST_BINS + 1);
  localparam int unsigned AW_ALL = $clog2(NSLOT);
  localparam int unsigned AW_SEC = $clog2(NUM_SEC * NSLOT);
  localparam int unsigned FDEPTH = 16;
  localparam int unsigned CW     = $clog2(FDEPTH + 1);
  localparam int unsigned RW     = 1 + 2 + BIN_W + 64;
  localparam logic signed [64:0] ACC_MAX = (65'sd1 <<< (ACC_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] ACC_MIN = -ACC_MAX - 65'sd1;

  logic [2:0] ring;
  logic       quartz;
  logic       moller;
  logic [7:0] det_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring    <= RING_RESET;
      quartz  <= 1'b1;
      moller  <= 1'b1;
      det_sel <= DETSEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RING:   ring    <= cfg_data[2:0];
        CFG_QUARTZ: quartz  <= cfg_data[0];
        CFG_MOLLER: moller  <= cfg_data[0];
        CFG_DETSEL: det_sel <= cfg_data;
      endcase
    end
  end

  logic              clr_busy;
  logic [AW_SEC-1:0] clr_addr;
  logic [CW-1:0]     cnt;
  logic              in_acc;
  logic              out_acc;

  assign in_ready = !clr_busy && (cnt < CW'(FDEPTH));
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      cnt      <= '0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW_SEC'(NUM_SEC * NSLOT - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      cnt <= cnt + CW'(in_acc) - CW'(out_acc);
    end
  end

  // Input stage: cuts that need only the request and the registers.
  logic               in_half;
  logic               in_origin;
  logic [32:0]        bin_prod;
  logic [10:0]        bin_q;
  logic signed [18:0] x_ext;
  logic signed [18:0] y_ext;

  assign x_ext     = 19'(pos_x);
  assign y_ext     = 19'(pos_y);
  assign in_origin = (pos_x == '0) && (pos_y == '0);
  assign in_half   = !((pos_y > 18'sd0) || ((pos_y == 18'sd0) && (pos_x > 18'sd0)));
  assign bin_prod  = 33'(radius) * 33'(BIN_RECIP);
  assign bin_q     = bin_prod[BIN_SHIFT+10:BIN_SHIFT];

  logic                v [6];
  item_t               p [6];
  logic [BIN_W-1:0]    hbin [6];
  logic [BIN_W-1:0]    rbin [6];
  logic                rok [6];
  logic signed [63:0]  prod [6];
  logic [31:0]         rate0;
  logic signed [31:0]  asym0;
  logic signed [18:0]  xf0;
  logic signed [18:0]  yf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_acc;
    end
    p[0].mode   <= mode;
    p[0].det_ok <= (detector_id == det_sel);
    p[0].mom_ok <= (momentum >= 24'(MIN_MOMENTUM));
    p[0].trk_ok <= (track_id <= (moller ? 16'd2 : 16'd1));
    p[0].hsel   <= hist_select;
    p[0].half   <= in_half;
    p[0].origin <= in_origin;
    p[0].radius <= radius;
    hbin[0]     <= (bin_q > 11'(HIST_BINS)) ? BIN_W'(HIST_BINS) : BIN_W'(bin_q);
    rbin[0]     <= bin_index;
    rok[0]      <= (bin_index <= BIN_W'(HIST_BINS));
    rate0       <= rate;
    asym0       <= asymmetry;
    xf0         <= in_half ? -x_ext : x_ext;
    yf0         <= in_half ? -y_ext : y_ext;
  end

  always_ff @(posedge clk) begin
    prod[0] <= '0;
    prod[1] <= 64'(signed'({1'b0, rate0})) * 64'(asym0);
  end

  for (genvar s = 1; s < 6; s++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else begin
        v[s] <= v[s-1];
      end
      p[s]    <= p[s-1];
      hbin[s] <= hbin[s-1];
      rbin[s] <= rbin[s-1];
      rok[s]  <= rok[s-1];
      if (s > 1) begin
        prod[s] <= prod[s-1];
      end
    end
  end

  logic [4:0] steps;

  shrc_angle u_angle (
    .clk (clk),
    .x   (xf0),
    .y   (yf0),
    .n   (steps)
  );

  // Classification, radial window and memory addresses.
  logic [5:0]        m5;
  logic [2:0]        ph;
  logic [1:0]        cls5;
  logic [16:0]       lo5;
  logic [16:0]       hi5;
  logic              ring_ok;
  logic              radial;
  logic              acc5;
  logic [AW_SEC-1:0] sec_base;
  logic [AW_SEC-1:0] rd_base;

  assign m5      = p[5].origin ? 6'd0 : (p[5].half ? 6'(steps) + 6'(HALF_STEPS) : 6'(steps));
  assign ph      = m5[2:0];
  assign cls5    = ((ph == 3'd0) || (ph == 3'd7)) ? CLS_CLOSED :
                   ((ph == 3'd3) || (ph == 3'd4)) ? CLS_OPEN : CLS_TRANS;
  assign lo5     = win_lo(quartz, ring, cls5);
  assign hi5     = win_hi(quartz, ring, cls5);
  assign ring_ok = (ring >= 3'd1) && (ring <= 3'd6);
  assign radial  = ring_ok && (p[5].radius >= lo5) &&
                   (quartz ? (p[5].radius < hi5) : (p[5].radius <= hi5));
  assign acc5    = p[5].det_ok && p[5].mom_ok && p[5].trk_ok && radial;

  always_comb begin
    priority case (cls5)
      CLS_CLOSED: sec_base = '0;
      CLS_TRANS:  sec_base = AW_SEC'(NSLOT);
      default:    sec_base = AW_SEC'(2 * NSLOT);
    endcase
    priority case (p[5].hsel)
      2'd1:    rd_base = '0;
      2'd2:    rd_base = AW_SEC'(NSLOT);
      default: rd_base = AW_SEC'(2 * NSLOT);
    endcase
  end

  logic               v6;
  logic               mode6;
  logic               acc6;
  logic [1:0]         cls6;
  logic [BIN_W-1:0]   hbin6;
  logic               rok6;
  logic               rd_all6;
  logic [AW_ALL-1:0]  addr_all6;
  logic [AW_SEC-1:0]  addr_sec6;
  logic signed [63:0] d6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v[5];
    end
    mode6     <= p[5].mode;
    acc6      <= acc5 && !p[5].mode;
    cls6      <= cls5;
    hbin6     <= hbin[5];
    rok6      <= rok[5];
    rd_all6   <= (p[5].hsel == HSEL_ALL);
    addr_all6 <= p[5].mode ? AW_ALL'(rbin[5]) : AW_ALL'(hbin[5]);
    addr_sec6 <= p[5].mode ? rd_base + AW_SEC'(rbin[5]) : sec_base + AW_SEC'(hbin[5]);
    d6        <= prod[5];
  end

  logic               v7;
  logic               mode7;
  logic               acc7;
  logic [1:0]         cls7;
  logic [BIN_W-1:0]   hbin7;
  logic               rok7;
  logic               rd_all7;
  logic [AW_ALL-1:0]  addr_all7;
  logic [AW_SEC-1:0]  addr_sec7;
  logic signed [63:0] d7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    mode7     <= mode6;
    acc7      <= acc6;
    cls7      <= cls6;
    hbin7     <= hbin6;
    rok7      <= rok6;
    rd_all7   <= rd_all6;
    addr_all7 <= addr_all6;
    addr_sec7 <= addr_sec6;
    d7        <= d6;
  end

  // Read-modify-write with forwarding of the write made in the previous cycle.
  logic [ACC_WIDTH-1:0] rd_all_q;
  logic [ACC_WIDTH-1:0] rd_sec_q;
  logic                 fw_all_v;
  logic                 fw_sec_v;
  logic [AW_ALL-1:0]    fw_all_addr;
  logic [AW_SEC-1:0]    fw_sec_addr;
  logic [ACC_WIDTH-1:0] fw_all_data;
  logic [ACC_WIDTH-1:0] fw_sec_data;
  logic [ACC_WIDTH-1:0] cur_all;
  logic [ACC_WIDTH-1:0] cur_sec;
  logic [ACC_WIDTH-1:0] new_all;
  logic [ACC_WIDTH-1:0] new_sec;
  logic signed [64:0]   sum_all;
  logic signed [64:0]   sum_sec;
  logic                 hit_we;

  assign cur_all = (fw_all_v && (fw_all_addr == addr_all7)) ? fw_all_data : rd_all_q;
  assign cur_sec = (fw_sec_v && (fw_sec_addr == addr_sec7)) ? fw_sec_data : rd_sec_q;
  assign sum_all = 65'(signed'(cur_all)) + 65'(d7);
  assign sum_sec = 65'(signed'(cur_sec)) + 65'(d7);
  assign new_all = (sum_all > ACC_MAX) ? ACC_MAX[ACC_WIDTH-1:0] :
                   (sum_all < ACC_MIN) ? ACC_MIN[ACC_WIDTH-1:0] : sum_all[ACC_WIDTH-1:0];
  assign new_sec = (sum_sec > ACC_MAX) ? ACC_MAX[ACC_WIDTH-1:0] :
                   (sum_sec < ACC_MIN) ? ACC_MIN[ACC_WIDTH-1:0] : sum_sec[ACC_WIDTH-1:0];
  assign hit_we  = v7 && acc7;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_all_v <= 1'b0;
      fw_sec_v <= 1'b0;
    end else begin
      fw_all_v <= hit_we;
      fw_sec_v <= hit_we;
    end
    fw_all_addr <= addr_all7;
    fw_sec_addr <= addr_sec7;
    fw_all_data <= new_all;
    fw_sec_data <= new_sec;
  end

  logic                 we_all;
  logic                 we_sec;
  logic [AW_ALL-1:0]    wa_all;
  logic [AW_SEC-1:0]    wa_sec;
  logic [ACC_WIDTH-1:0] wd_all;
  logic [ACC_WIDTH-1:0] wd_sec;

  assign we_all = clr_busy ? (clr_addr < AW_SEC'(NSLOT)) : hit_we;
  assign we_sec = clr_busy || hit_we;
  assign wa_all = clr_busy ? AW_ALL'(clr_addr) : addr_all7;
  assign wa_sec = clr_busy ? clr_addr : addr_sec7;
  assign wd_all = clr_busy ? '0 : new_all;
  assign wd_sec = clr_busy ? '0 : new_sec;

  shrc_ram #(.WIDTH(ACC_WIDTH), .DEPTH(NSLOT)) u_ram_all (
    .clk   (clk),
    .we    (we_all),
    .waddr (wa_all),
    .wdata (wd_all),
    .raddr (addr_all6),
    .rdata (rd_all_q)
  );

  shrc_ram #(.WIDTH(ACC_WIDTH), .DEPTH(NUM_SEC * NSLOT)) u_ram_sec (
    .clk   (clk),
    .we    (we_sec),
    .waddr (wa_sec),
    .wdata (wd_sec),
    .raddr (addr_sec6),
    .rdata (rd_sec_q)
  );

  // Result assembly and queue.
  logic signed [63:0] rd_val;
  logic [RW-1:0]      res_in;
  logic [RW-1:0]      res_out;
  logic               q_empty;

  assign rd_val = !rok7 ? 64'sd0 :
                  rd_all7 ? 64'(signed'(cur_all)) : 64'(signed'(cur_sec));
  assign res_in = mode7 ? {1'b0, 2'd0, BIN_W'(0), rd_val}
                        : {acc7, cls7, hbin7, 64'd0};

  shrc_fifo #(.WIDTH(RW), .DEPTH(FDEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (v7),
    .din   (res_in),
    .pop   (out_acc),
    .dout  (res_out),
    .empty (q_empty)
  );

  assign out_valid    = !q_empty;
  assign accepted     = res_out[RW-1];
  assign sector_class = res_out[RW-2:RW-3];
  assign hit_bin      = res_out[BIN_W+63:64];
  assign bin_value    = signed'(res_out[63:0]);

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready)
    else $error("Request taken during the clearing pass.");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(FDEPTH))
    else $error("Outstanding request count exceeds the queue depth.");

  a_pipe_empty_after_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (!v7 && !v6 && q_empty))
    else $error("Pipeline active during the clearing pass.");

  a_hit_no_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (bin_value == 64'sd0))
    else $error("Accepted hit carries an accumulator value.");

endmodule

`default_nettype wire

### tb/sv/tb_sector_radial_cut_histogrammer_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Sector radial-cut histogrammer testbench
// Drives hit and histogram-read requests through the valid/ready channels
// with random gaps and output stalls, and steps a local copy of the cut and
// accumulation logic over the configuration settings to check every result.
// ============================================================================

module tb_sector_radial_cut_histogrammer_core;
  import shrc_pkg::*;

  localparam int NBIN = 400;
  localparam int NSLOT = NBIN + 1;
  localparam int BIN_UNITS = 80;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic MODE_HIT = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  typedef struct {
    logic               mode;
    logic [7:0]         det;
    logic [15:0]        trk;
    logic [23:0]        mom;
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic [16:0]        rad;
    logic [31:0]        rate;
    logic signed [31:0] asym;
    logic [1:0]         hsel;
    logic [8:0]         bidx;
    bit                 typed;
    logic               e_acc;
    logic [1:0]         e_cls;
    logic [8:0]         e_bin;
    longint             e_val;
  } request_t;

  typedef struct {
    logic       acc;
    logic [1:0] cls;
    logic [8:0] bin;
    longint     val;
  } result_t;

  const int step_cos[15] = '{65536, 65124, 63893, 61858, 59046, 55491, 51238, 46341,
                             40861, 34867, 28435, 21645, 14583, 7338, 0};
  const int win_lo_tab[2][6][3] = '{
    '{'{10880, 10880, 10880}, '{11680, 11680, 11680}, '{13360, 13240, 12880},
      '{14640, 14400, 13680}, '{16880, 16960, 17120}, '{18720, 18720, 18720}},
    '{'{10240, 10240, 10240}, '{10880, 10880, 10880}, '{11680, 11680, 11680},
      '{13360, 13240, 12880}, '{9600, 9600, 9600}, '{16880, 16960, 17120}}};
  const int win_hi_tab[2][6][3] = '{
    '{'{30400, 30400, 30400}, '{30400, 30400, 30400}, '{30400, 30400, 30400},
      '{30400, 30400, 30400}, '{30400, 30400, 30400}, '{30400, 30400, 30400}},
    '{'{10880, 10880, 10880}, '{11680, 11680, 11680}, '{13360, 13240, 12880},
      '{14640, 14400, 13680}, '{20800, 20800, 20800}, '{18720, 18720, 18720}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic [7:0] detector_id = '0;
  logic [15:0] track_id = '0;
  logic [23:0] momentum = '0;
  logic signed [17:0] pos_x = '0;
  logic signed [17:0] pos_y = '0;
  logic [16:0] radius = '0;
  logic [31:0] rate = '0;
  logic signed [31:0] asymmetry = '0;
  logic [1:0] hist_select = '0;
  logic [8:0] bin_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic accepted;
  logic [1:0] sector_class;
  logic [8:0] hit_bin;
  logic signed [63:0] bin_value;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  longint hist_store[4 * NSLOT];
  logic [2:0] ring_sel;
  logic quartz_sel;
  logic moller_sel;
  logic [7:0] det_sel;

  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit quiet = 0;
  logic [8:0] last_bin = '0;
  request_t dir_tab[17];

  sector_radial_cut_histogrammer_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .detector_id(detector_id), .track_id(track_id), .momentum(momentum),
    .pos_x(pos_x), .pos_y(pos_y), .radius(radius), .rate(rate),
    .asymmetry(asymmetry), .hist_select(hist_select), .bin_index(bin_index),
    .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
    .sector_class(sector_class), .hit_bin(hit_bin), .bin_value(bin_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned half_turn_steps(longint x, longint y);
    int unsigned n;
    longint c;
    longint s;
    n = 0;
    for (int k = 1; k <= 27; k++) begin
      c = (k <= 14) ? step_cos[k] : -step_cos[28 - k];
      s = step_cos[(k <= 14) ? (14 - k) : (k - 14)];
      if (c * y - s * x >= 0) n++;
    end
    return n;
  endfunction

  function automatic logic [1:0] sector_of(longint x, longint y);
    int unsigned m;
    int unsigned p;
    if (x == 0 && y == 0) m = 0;
    else if (y > 0 || (y == 0 && x > 0)) m = half_turn_steps(x, y);
    else m = 28 + half_turn_steps(-x, -y);
    p = m % 8;
    if (p == 0 || p == 7) return CLS_CLOSED;
    if (p == 3 || p == 4) return CLS_OPEN;
    return CLS_TRANS;
  endfunction

  function automatic longint sat_add(longint a, longint d);
    if (d > 0 && a > ACC_MAX - d) return ACC_MAX;
    if (d < 0 && a < ACC_MIN - d) return ACC_MIN;
    return a + d;
  endfunction

  function automatic result_t histogram_step(request_t r);
    result_t res;
    int unsigned b;
    int lo;
    int hi;
    bit in_win;
    longint w;
    res = '{1'b0, 2'd0, 9'd0, 0};
    if (r.mode == MODE_READ) begin
      if (r.bidx <= NBIN) res.val = hist_store[r.hsel * NSLOT + r.bidx];
      return res;
    end
    res.cls = sector_of(longint'(r.px), longint'(r.py));
    b = r.rad / BIN_UNITS;
    if (b > NBIN) b = NBIN;
    res.bin = b;
    in_win = 0;
    if (ring_sel >= 1 && ring_sel <= 6) begin
      lo = win_lo_tab[quartz_sel][ring_sel - 1][res.cls];
      hi = win_hi_tab[quartz_sel][ring_sel - 1][res.cls];
      in_win = (r.rad >= lo) && (quartz_sel ? (r.rad < hi) : (r.rad <= hi));
    end
    if (r.det == det_sel && r.mom >= MIN_MOMENTUM && r.trk <= (moller_sel ? 2 : 1)
        && in_win) begin
      w = longint'(r.rate) * longint'(r.asym);
      hist_store[b] = sat_add(hist_store[b], w);
      hist_store[(res.cls + 1) * NSLOT + b] = sat_add(hist_store[(res.cls + 1) * NSLOT + b], w);
      res.acc = 1'b1;
    end
    return res;
  endfunction

  function automatic request_t hit_req(logic [7:0] d, logic [15:0] t, logic [23:0] m,
                                       int x, int y, int rd, logic [31:0] rt,
                                       logic [31:0] a);
    request_t r;
    r = '{MODE_HIT, d, t, m, x, y, rd, rt, a, 2'd0, 9'd0, 0, 1'b0, 2'd0, 9'd0, 0};
    return r;
  endfunction

  function automatic request_t read_req(logic [1:0] h, logic [8:0] b);
    request_t r;
    r = '{MODE_READ, 8'd0, 16'd0, 24'd0, 18'sd0, 18'sd0, 17'd0, 32'd0, 32'sd0, h, b,
          0, 1'b0, 2'd0, 9'd0, 0};
    return r;
  endfunction

  function automatic request_t with_result(request_t r, logic a, logic [1:0] c,
                                           logic [8:0] b, longint v);
    r.typed = 1;
    r.e_acc = a;
    r.e_cls = c;
    r.e_bin = b;
    r.e_val = v;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      r = read_req($urandom_range(3), ($urandom_range(3) == 0) ? $urandom_range(511)
                                                                : last_bin);
      return r;
    end
    r = hit_req(($urandom_range(15) == 0) ? $urandom_range(255) : det_sel,
                ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(3),
                ($urandom_range(9) == 0) ? $urandom_range(300)
                                         : $urandom_range(256, 24'hFFFFFF),
                $urandom_range(262143), $urandom_range(262143),
                ($urandom_range(9) == 0) ? $urandom_range(131071)
                                         : $urandom_range(9000, 31000),
                $urandom(), $urandom());
    if (pick < 25) begin
      r.px = $urandom_range(40) - 20;
      r.py = $urandom_range(40) - 20;
    end
    if (pick >= 90) begin
      r.rad = 17'd12000 + 17'(80 * $urandom_range(3));
      r.rate = 32'hFFFF_FFFF;
      r.asym = (pick & 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int g;
    if (quiet) return 0;
    g = $urandom_range(99);
    if (g < 60) return 0;
    if (g < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(request_t r);
    result_t res;
    int gap;
    in_valid <= 1'b1;
    mode <= r.mode;
    detector_id <= r.det;
    track_id <= r.trk;
    momentum <= r.mom;
    pos_x <= r.px;
    pos_y <= r.py;
    radius <= r.rad;
    rate <= r.rate;
    asymmetry <= r.asym;
    hist_select <= r.hsel;
    bin_index <= r.bidx;
    do @(posedge clk); while (!in_ready);
    res = histogram_step(r);
    if (r.mode == MODE_HIT) last_bin = res.bin;
    if (r.typed) res = '{r.e_acc, r.e_cls, r.e_bin, r.e_val};
    pending_results.push_back(res);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic apply_setting(logic [2:0] ring, logic q, logic m, logic [7:0] d);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RING;
    cfg_data <= {5'd0, ring};
    @(posedge clk);
    cfg_index <= CFG_QUARTZ;
    cfg_data <= {7'd0, q};
    @(posedge clk);
    cfg_index <= CFG_MOLLER;
    cfg_data <= {7'd0, m};
    @(posedge clk);
    cfg_index <= CFG_DETSEL;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_sel = ring;
    quartz_sel = q;
    moller_sel = m;
    det_sel = d;
  endtask

  task automatic note_mismatch(string field, longint e, longint a);
    errors++;
    if (errors <= 10) $display("Mismatch in %s: expected %0d, got %0d", field, e, a);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(9) == 0)
        stall_left <= ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result count", 0, 1);
      end else begin
        e = pending_results.pop_front();
        if (accepted !== e.acc) note_mismatch("accepted", e.acc, accepted);
        if (sector_class !== e.cls) note_mismatch("sector_class", e.cls, sector_class);
        if (hit_bin !== e.bin) note_mismatch("hit_bin", e.bin, hit_bin);
        if (bin_value !== e.val) note_mismatch("bin_value", e.val, bin_value);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [2:0] rings[8] = '{3'd1, 3'd0, 3'd6, 3'd7, 3'd3, 3'd5, 3'd4, 3'd2};
    logic quartz[8] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic moller[8] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    logic [7:0] dets[8] = '{8'd28, 8'd0, 8'd255, 8'd28, 8'd100, 8'd28, 8'd28, 8'd170};
    foreach (hist_store[i]) hist_store[i] = 0;
    ring_sel = RING_RESET;
    quartz_sel = 1'b1;
    moller_sel = 1'b1;
    det_sel = DETSEL_RESET;

    dir_tab[0] = with_result(read_req(HSEL_ALL, 9'd0), 1'b0, CLS_CLOSED, 9'd0, 0);
    dir_tab[1] = with_result(read_req(2'd3, 9'd400), 1'b0, CLS_CLOSED, 9'd0, 0);
    dir_tab[2] = with_result(read_req(2'd3, 9'd511), 1'b0, CLS_CLOSED, 9'd0, 0);
    dir_tab[3] = with_result(hit_req(8'd27, 16'd0, 24'hFFFFFF, 0, 0, 0, 32'd1, 32'd1),
                             1'b0, CLS_CLOSED, 9'd0, 0);
    dir_tab[4] = with_result(hit_req(8'd28, 16'd0, 24'd255, 100, 0, 10500, 32'd1, 32'd1),
                             1'b0, CLS_CLOSED, 9'd131, 0);
    dir_tab[5] = hit_req(8'd28, 16'd2, 24'd256, 100, 0, 10240, 32'd1, 32'hFFFF_FFFF);
    dir_tab[6] = hit_req(8'd28, 16'd3, 24'd256, 100, 0, 10400, 32'd5, 32'd5);
    dir_tab[7] = hit_req(8'd28, 16'd1, 24'd256, 100, 0, 10880, 32'd5, 32'd5);
    dir_tab[8] = with_result(hit_req(8'd28, 16'd0, 24'd300, -131072, 0, 131071, 32'd1,
                                     32'd1), 1'b0, CLS_OPEN, 9'd400, 0);
    dir_tab[9] = hit_req(8'd28, 16'd0, 24'd300, 0, 131071, 10300, 32'hFFFF_FFFF,
                         32'h7FFF_FFFF);
    dir_tab[10] = dir_tab[9];
    dir_tab[11] = hit_req(8'd28, 16'd1, 24'd999, 5000, 1, 10400, 32'hFFFF_FFFF,
                          32'h8000_0000);
    dir_tab[12] = dir_tab[11];
    dir_tab[13] = read_req(HSEL_ALL, 9'd128);
    dir_tab[14] = read_req(2'd2, 9'd128);
    dir_tab[15] = hit_req(8'd28, 16'd0, 24'hFFFFFF, -5, -7, 10700, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF);
    dir_tab[16] = read_req(2'd1, 9'd130);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i]) send_request(dir_tab[i]);
    for (int ph = 0; ph < 8; ph++) begin
      apply_setting(rings[ph], quartz[ph], moller[ph], dets[ph]);
      quiet = (ph % 3 == 2);
      for (int n = 0; n < 125; n++) send_request(random_request());
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
sv/shrc_pkg.sv
sv/shrc_ram.sv
sv/shrc_angle.sv
sv/shrc_fifo.sv
sv/sector_radial_cut_histogrammer_core.sv
tb/sv/tb_sector_radial_cut_histogrammer_core.sv
